// File: rtl/lsua64_pkg.sv
// Shared constants, codes and request types of the load/store unit.
`timescale 1ns / 1ps
package lsua64_pkg;

  localparam int MEM_WORDS = 262144;
  localparam int NUM_REGS  = 32;
  localparam int XLEN      = 64;
  localparam int WORD_AW   = $clog2(MEM_WORDS);
  localparam int BYTE_AW   = WORD_AW + 3;
  localparam int REG_AW    = $clog2(NUM_REGS);
  localparam int EFF_W     = 21;

  localparam logic [1:0] MODE_EXEC    = 2'd0;
  localparam logic [1:0] MODE_SET_REG = 2'd1;
  localparam logic [1:0] MODE_SET_MEM = 2'd2;

  typedef struct packed {
    logic [REG_AW-1:0] ra_a;
    logic [REG_AW-1:0] ra_b;
    logic              we;
    logic [REG_AW-1:0] wa;
    logic [XLEN-1:0]   wd;
  } rf_req_t;

  typedef struct packed {
    logic               re;
    logic [WORD_AW-1:0] ra;
    logic               we;
    logic [WORD_AW-1:0] wa;
    logic [XLEN-1:0]    wd;
    logic [7:0]         be;
  } dm_req_t;

endpackage

// File: rtl/lsua64_regfile.sv
// Register file: 32 x 64 bits, two registered read ports, one write port.
`timescale 1ns / 1ps
module lsua64_regfile (
  input  logic                    clk,
  input  logic                    rst_n,
  input  lsua64_pkg::rf_req_t     req,
  output logic [lsua64_pkg::XLEN-1:0] rd_a,
  output logic [lsua64_pkg::XLEN-1:0] rd_b
);

  logic [lsua64_pkg::XLEN-1:0]     mem [lsua64_pkg::NUM_REGS];
  logic [lsua64_pkg::NUM_REGS-1:0] valid_r;
  logic [lsua64_pkg::XLEN-1:0]     rd_a_r;
  logic [lsua64_pkg::XLEN-1:0]     rd_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (req.we) begin
      valid_r[req.wa] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.wa] <= req.wd;
    end
    rd_a_r <= valid_r[req.ra_a] ? mem[req.ra_a] : '0;
    rd_b_r <= valid_r[req.ra_b] ? mem[req.ra_b] : '0;
  end

  assign rd_a = rd_a_r;
  assign rd_b = rd_b_r;

endmodule

// File: rtl/lsua64_dmem.sv
// Data memory: 64-bit words, byte-enable write port, registered read port.
`timescale 1ns / 1ps
module lsua64_dmem (
  input  logic                        clk,
  input  lsua64_pkg::dm_req_t         req,
  output logic [lsua64_pkg::XLEN-1:0] rdata
);

  logic [lsua64_pkg::XLEN-1:0] mem [lsua64_pkg::MEM_WORDS];
  logic [lsua64_pkg::XLEN-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      for (int b = 0; b < 8; b++) begin
        if (req.be[b]) begin
          mem[req.wa][8*b +: 8] <= req.wd[8*b +: 8];
        end
      end
    end
    if (req.re) begin
      rdata_r <= mem[req.ra];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/load_store_unit_a64.sv
// Load/store unit top level: sequencer over the register file and data memory.
// One word in flight; the next input is taken only after the result is registered,
// and the result is held in S_RESP while the output register is full and stalled.
// Each access does a register read, an address add and two single-port memory
// accesses (low word in S_DATA, high word in S_LD1 or S_ST1); a preset writes in S_IDLE.
// Synchronous active-low reset idles the sequencer, empties the output and clears the register file.
`timescale 1ns / 1ps
module load_store_unit_a64 (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_mode,
  input  logic [31:0] in_instr_word,
  input  logic [20:0] in_pc_value,
  input  logic [17:0] in_preset_index,
  input  logic [63:0] in_preset_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [20:0] out_eff_address,
  output logic        out_is_load,
  output logic [4:0]  out_target_reg,
  output logic [63:0] out_moved_data,
  output logic        out_base_written
);

  typedef enum logic [2:0] {
    S_IDLE, S_ADDR, S_DATA, S_LD1, S_LD2, S_ST1, S_RESP
  } state_t;

  state_t                             state_r;
  logic [31:0]                        instr_r;
  logic [20:0]                        pc_r;
  logic [lsua64_pkg::BYTE_AW-1:0]     addr_r;
  logic [63:0]                        wb_val_r;
  logic                               base_wb_r;
  logic [63:0]                        lo_r;
  logic [63:0]                        st_hi_r;
  logic [7:0]                         st_hi_be_r;
  logic [lsua64_pkg::EFF_W-1:0]       res_addr_r;
  logic                               res_load_r;
  logic [4:0]                         res_rt_r;
  logic [63:0]                        res_data_r;
  logic                               res_bwb_r;
  logic                               out_valid_r;
  logic [lsua64_pkg::EFF_W-1:0]       out_addr_r;
  logic                               out_load_r;
  logic [4:0]                         out_rt_r;
  logic [63:0]                        out_data_r;
  logic                               out_bwb_r;

  lsua64_pkg::rf_req_t                rf_req;
  lsua64_pkg::dm_req_t                dm_req;
  logic [63:0]                        rf_rd_a;
  logic [63:0]                        rf_rd_b;
  logic [63:0]                        dm_rdata;

  logic [4:0]                         rt;
  logic [4:0]                         xn;
  logic                               size8;
  logic                               is_ld;
  logic                               pre_post;
  logic [63:0]                        s9;
  logic [63:0]                        s19;
  logic [63:0]                        imm12;
  logic [63:0]                        base_sum;
  logic [63:0]                        addr64;
  logic [63:0]                        rt_val;
  logic [63:0]                        st_data;
  logic [127:0]                       st_wide;
  logic [15:0]                        st_be16;
  logic [127:0]                       ld_wide;
  logic [63:0]                        ld_data;
  logic [lsua64_pkg::WORD_AW-1:0]     word_lo;
  logic [lsua64_pkg::WORD_AW-1:0]     word_hi;
  logic [5:0]                         shamt;
  logic                               in_acc;

  lsua64_regfile u_regfile (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (rf_req),
    .rd_a  (rf_rd_a),
    .rd_b  (rf_rd_b)
  );

  lsua64_dmem u_dmem (
    .clk   (clk),
    .req   (dm_req),
    .rdata (dm_rdata)
  );

  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;

  assign rt       = instr_r[4:0];
  assign xn       = instr_r[9:5];
  assign size8    = instr_r[30];
  assign is_ld    = instr_r[31] ? instr_r[22] : 1'b1;
  assign pre_post = instr_r[31] && !instr_r[24] && !instr_r[21];
  assign s9       = {{55{instr_r[20]}}, instr_r[20:12]};
  assign s19      = {{43{instr_r[23]}}, instr_r[23:5], 2'b00};
  assign imm12    = size8 ? {49'b0, instr_r[21:10], 3'b000} : {50'b0, instr_r[21:10], 2'b00};
  assign base_sum = rf_rd_a + s9;

  always_comb begin
    priority if (!instr_r[31]) begin
      addr64 = {43'b0, pc_r} + s19;
    end else if (instr_r[24]) begin
      addr64 = rf_rd_a + imm12;
    end else if (instr_r[21]) begin
      addr64 = rf_rd_a + rf_rd_b;
    end else begin
      addr64 = instr_r[11] ? base_sum : rf_rd_a;
    end
  end

  assign shamt   = {addr_r[2:0], 3'b000};
  assign word_lo = addr_r[lsua64_pkg::BYTE_AW-1:3];
  assign word_hi = word_lo + lsua64_pkg::WORD_AW'(1);
  assign rt_val  = (base_wb_r && (rt == xn)) ? wb_val_r : rf_rd_b;
  assign st_data = size8 ? rt_val : {32'b0, rt_val[31:0]};
  assign st_wide = {64'b0, st_data} << shamt;
  assign st_be16 = (size8 ? 16'h00FF : 16'h000F) << addr_r[2:0];
  assign ld_wide = {dm_rdata, lo_r} >> shamt;
  assign ld_data = size8 ? ld_wide[63:0] : {32'b0, ld_wide[31:0]};

  always_comb begin
    rf_req      = '0;
    dm_req      = '0;
    rf_req.ra_a = xn;
    rf_req.ra_b = rt;
    unique case (state_r)
      S_IDLE: begin
        rf_req.ra_a = in_instr_word[9:5];
        rf_req.ra_b = in_instr_word[20:16];
        if (in_acc && (in_mode == lsua64_pkg::MODE_SET_REG)) begin
          rf_req.we = 1'b1;
          rf_req.wa = in_preset_index[lsua64_pkg::REG_AW-1:0];
          rf_req.wd = in_preset_value;
        end
        if (in_acc && (in_mode == lsua64_pkg::MODE_SET_MEM)) begin
          dm_req.we = 1'b1;
          dm_req.wa = in_preset_index[lsua64_pkg::WORD_AW-1:0];
          dm_req.wd = in_preset_value;
          dm_req.be = 8'hFF;
        end
      end
      S_ADDR: begin
        if (pre_post) begin
          rf_req.we = 1'b1;
          rf_req.wa = xn;
          rf_req.wd = base_sum;
        end
      end
      S_DATA: begin
        if (is_ld) begin
          dm_req.re = 1'b1;
          dm_req.ra = word_lo;
        end else begin
          dm_req.we = 1'b1;
          dm_req.wa = word_lo;
          dm_req.wd = st_wide[63:0];
          dm_req.be = st_be16[7:0];
        end
      end
      S_LD1: begin
        dm_req.re = 1'b1;
        dm_req.ra = word_hi;
      end
      S_LD2: begin
        rf_req.we = 1'b1;
        rf_req.wa = rt;
        rf_req.wd = ld_data;
      end
      S_ST1: begin
        dm_req.we = |st_hi_be_r;
        dm_req.wa = word_hi;
        dm_req.wd = st_hi_r;
        dm_req.be = st_hi_be_r;
      end
      S_RESP: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      base_wb_r   <= 1'b0;
    end else begin
      if (out_ready && (state_r != S_RESP)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            instr_r    <= in_instr_word;
            pc_r       <= in_pc_value;
            base_wb_r  <= 1'b0;
            res_addr_r <= '0;
            res_load_r <= 1'b0;
            res_rt_r   <= '0;
            res_data_r <= '0;
            res_bwb_r  <= 1'b0;
            unique case (in_mode)
              lsua64_pkg::MODE_EXEC: begin
                state_r <= S_ADDR;
              end
              lsua64_pkg::MODE_SET_REG: begin
                res_rt_r   <= in_preset_index[4:0];
                res_data_r <= in_preset_value;
                state_r    <= S_RESP;
              end
              lsua64_pkg::MODE_SET_MEM: begin
                res_addr_r <= lsua64_pkg::EFF_W'(
                  {in_preset_index[lsua64_pkg::WORD_AW-1:0], 3'b000});
                res_data_r <= in_preset_value;
                state_r    <= S_RESP;
              end
              default: begin
                state_r <= S_RESP;
              end
            endcase
          end
        end
        S_ADDR: begin
          addr_r <= addr64[lsua64_pkg::BYTE_AW-1:0];
          if (pre_post) begin
            base_wb_r <= 1'b1;
            wb_val_r  <= base_sum;
          end
          state_r <= S_DATA;
        end
        S_DATA: begin
          res_addr_r <= lsua64_pkg::EFF_W'(addr_r);
          res_load_r <= is_ld;
          res_rt_r   <= rt;
          res_bwb_r  <= base_wb_r;
          if (is_ld) begin
            state_r <= S_LD1;
          end else begin
            st_hi_r    <= st_wide[127:64];
            st_hi_be_r <= st_be16[15:8];
            res_data_r <= st_data;
            state_r    <= S_ST1;
          end
        end
        S_LD1: begin
          lo_r    <= dm_rdata;
          state_r <= S_LD2;
        end
        S_LD2: begin
          res_data_r <= ld_data;
          state_r    <= S_RESP;
        end
        S_ST1: begin
          state_r <= S_RESP;
        end
        S_RESP: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_addr_r  <= res_addr_r;
            out_load_r  <= res_load_r;
            out_rt_r    <= res_rt_r;
            out_data_r  <= res_data_r;
            out_bwb_r   <= res_bwb_r;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_eff_address  = out_addr_r;
  assign out_is_load      = out_load_r;
  assign out_target_reg   = out_rt_r;
  assign out_moved_data   = out_data_r;
  assign out_base_written = out_bwb_r;

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while a word is in flight");

  a_one_write_port: assert property (@(posedge clk) disable iff (!rst_n)
    !(rf_req.we && dm_req.we))
    else $error("register file and memory written in the same cycle");

  a_base_wb_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ADDR) && rf_req.we |-> pre_post)
    else $error("base write-back outside pre/post indexing");

  a_store_mask: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DATA) && !is_ld |-> dm_req.we && (dm_req.be != 8'h00))
    else $error("store issued with empty byte mask");

  a_load_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LD2) |-> $past(state_r) == S_LD1)
    else $error("load completed without reading the upper word");
`endif

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for the load/store unit: directed and random words against a predictor.
`timescale 1ns / 1ps
module tb_top;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int STALL_LIMIT = 400;
  localparam int RANDOM_WORDS = 1500;
  localparam int TOTAL_WORDS = 1650;

  typedef struct packed {
    logic [20:0] eff_address;
    logic        is_load;
    logic [4:0]  target_reg;
    logic [63:0] moved_data;
    logic        base_written;
  } access_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_mode = lsua64_pkg::MODE_EXEC;
  logic [31:0] in_instr_word = '0;
  logic [20:0] in_pc_value = '0;
  logic [17:0] in_preset_index = '0;
  logic [63:0] in_preset_value = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [20:0] out_eff_address;
  logic        out_is_load;
  logic [4:0]  out_target_reg;
  logic [63:0] out_moved_data;
  logic        out_base_written;

  logic [63:0] gpr [lsua64_pkg::NUM_REGS];
  logic [63:0] dmem [lsua64_pkg::MEM_WORDS];
  bit          dmem_valid [lsua64_pkg::MEM_WORDS];
  access_t     access_q [$];
  int          words_sent = 0;
  int          mismatches = 0;
  bit          src_gaps = 1'b1;
  bit          sink_stalls = 1'b1;

  load_store_unit_a64 i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_mode          (in_mode),
    .in_instr_word    (in_instr_word),
    .in_pc_value      (in_pc_value),
    .in_preset_index  (in_preset_index),
    .in_preset_value  (in_preset_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_eff_address  (out_eff_address),
    .out_is_load      (out_is_load),
    .out_target_reg   (out_target_reg),
    .out_moved_data   (out_moved_data),
    .out_base_written (out_base_written)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    for (int r = 0; r < lsua64_pkg::NUM_REGS; r++) begin
      gpr[r] = '0;
    end
  end

  function automatic logic [31:0] enc_uoff(logic sz8, logic ld, logic [11:0] imm,
                                           logic [4:0] xn, logic [4:0] rt);
    return {1'b1, sz8, 6'b111001, 1'b0, ld, imm, xn, rt};
  endfunction

  function automatic logic [31:0] enc_idx(logic sz8, logic ld, logic [8:0] s9, logic pre,
                                          logic [4:0] xn, logic [4:0] rt);
    return {1'b1, sz8, 6'b111000, 1'b0, ld, 1'b0, s9, pre, 1'b1, xn, rt};
  endfunction

  function automatic logic [31:0] enc_roff(logic sz8, logic ld, logic [4:0] xm,
                                           logic [4:0] xn, logic [4:0] rt);
    return {1'b1, sz8, 6'b111000, 1'b0, ld, 1'b1, xm, 6'b011010, xn, rt};
  endfunction

  function automatic logic [31:0] enc_lit(logic sz8, logic [18:0] s19, logic [4:0] rt);
    return {1'b0, sz8, 6'b011000, s19, rt};
  endfunction

  function automatic logic [20:0] access_addr(logic [31:0] ins, logic [20:0] pc);
    logic [63:0] base;
    logic [63:0] sum;
    base = gpr[ins[9:5]];
    if (!ins[31]) begin
      sum = 64'(pc) + ({{45{ins[23]}}, ins[23:5]} << 2);
    end else if (ins[24]) begin
      sum = base + (ins[30] ? 64'({ins[21:10], 3'b000}) : 64'({ins[21:10], 2'b00}));
    end else if (ins[21]) begin
      sum = base + gpr[ins[20:16]];
    end else if (ins[11]) begin
      sum = base + {{55{ins[20]}}, ins[20:12]};
    end else begin
      sum = base;
    end
    return sum[20:0];
  endfunction

  function automatic access_t model_access(logic [1:0] mode, logic [31:0] ins,
                                           logic [20:0] pc, logic [17:0] pidx,
                                           logic [63:0] pval);
    access_t     r;
    logic [20:0] addr;
    logic [20:0] ba;
    logic [63:0] data;
    int          nbytes;
    r = '0;
    case (mode)
      lsua64_pkg::MODE_SET_REG: begin
        gpr[pidx[4:0]] = pval;
        r.target_reg = pidx[4:0];
        r.moved_data = pval;
      end
      lsua64_pkg::MODE_SET_MEM: begin
        dmem[pidx] = pval;
        dmem_valid[pidx] = 1'b1;
        r.eff_address = {pidx, 3'b000};
        r.moved_data = pval;
      end
      lsua64_pkg::MODE_EXEC: begin
        addr = access_addr(ins, pc);
        nbytes = ins[30] ? 8 : 4;
        r.is_load = !ins[31] || ins[22];
        if (ins[31] && !ins[24] && !ins[21]) begin
          gpr[ins[9:5]] = gpr[ins[9:5]] + {{55{ins[20]}}, ins[20:12]};
          r.base_written = 1'b1;
        end
        if (r.is_load) begin
          data = '0;
        end else begin
          data = gpr[ins[4:0]];
          if (nbytes == 4) begin
            data[63:32] = '0;
          end
        end
        for (int i = 0; i < nbytes; i++) begin
          ba = addr + 21'(i);
          if (r.is_load) begin
            data[8*i +: 8] = dmem[ba[20:3]][8*ba[2:0] +: 8];
          end else begin
            dmem[ba[20:3]][8*ba[2:0] +: 8] = data[8*i +: 8];
          end
        end
        if (r.is_load) begin
          gpr[ins[4:0]] = data;
        end
        r.eff_address = addr;
        r.target_reg = ins[4:0];
        r.moved_data = data;
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  task automatic send_word(logic [1:0] mode, logic [31:0] ins, logic [20:0] pc,
                           logic [17:0] pidx, logic [63:0] pval);
    int gap;
    gap = src_gaps ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= mode;
    in_instr_word <= ins;
    in_pc_value <= pc;
    in_preset_index <= pidx;
    in_preset_value <= pval;
    do @(posedge clk); while (!in_ready);
    access_q.push_back(model_access(mode, ins, pc, pidx, pval));
    words_sent++;
  endtask

  // preset any memory word the access touches that holds no defined data yet, then send the access
  task automatic exec_word(logic [31:0] ins, logic [20:0] pc);
    logic [20:0] lo_addr;
    logic [20:0] hi_addr;
    lo_addr = access_addr(ins, pc);
    hi_addr = lo_addr + (ins[30] ? 21'd7 : 21'd3);
    if (!dmem_valid[lo_addr[20:3]]) begin
      send_word(lsua64_pkg::MODE_SET_MEM, $urandom, 21'($urandom), lo_addr[20:3],
                {$urandom, $urandom});
    end
    if (!dmem_valid[hi_addr[20:3]]) begin
      send_word(lsua64_pkg::MODE_SET_MEM, $urandom, 21'($urandom), hi_addr[20:3],
                {$urandom, $urandom});
    end
    send_word(lsua64_pkg::MODE_EXEC, ins, pc, 18'($urandom), {$urandom, $urandom});
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (access_q.size() != 0);
  endtask

  task automatic test_reset_presets();
    exec_word(enc_uoff(1'b1, 1'b0, 12'd0, 5'd0, 5'd7), 21'd0);
    send_word(lsua64_pkg::MODE_SET_REG, $urandom, 21'($urandom), 18'h3FFFF, {64{1'b1}});
    send_word(lsua64_pkg::MODE_SET_REG, $urandom, 21'($urandom), 18'h00020,
              64'h8000_0000_0000_0001);
    send_word(lsua64_pkg::MODE_SET_MEM, $urandom, 21'($urandom), 18'h3FFFF,
              64'h0123_4567_89AB_CDEF);
    send_word(lsua64_pkg::MODE_SET_MEM, $urandom, 21'($urandom), 18'h00000,
              64'hFEDC_BA98_7654_3210);
    send_word(MODE_UNUSED, $urandom, 21'($urandom), 18'($urandom), {$urandom, $urandom});
    wait_drained();
  endtask

  task automatic test_addressing();
    send_word(lsua64_pkg::MODE_SET_REG, $urandom, 21'($urandom), 18'd0,
              {43'h123_4567_89AB, 21'h1FFFFD});
    exec_word(enc_uoff(1'b1, 1'b1, 12'd0, 5'd0, 5'd1), 21'($urandom));
    exec_word(enc_idx(1'b0, 1'b0, 9'h100, 1'b1, 5'd2, 5'd31), 21'($urandom));
    exec_word(enc_idx(1'b0, 1'b1, 9'h0FF, 1'b0, 5'd2, 5'd2), 21'($urandom));
    exec_word(enc_idx(1'b1, 1'b0, 9'd8, 1'b1, 5'd3, 5'd3), 21'($urandom));
    wait_drained();
    exec_word(enc_uoff(1'b1, 1'b1, 12'hFFF, 5'd31, 5'd4), 21'($urandom));
    exec_word(enc_uoff(1'b0, 1'b0, 12'hFFF, 5'd0, 5'd1), 21'($urandom));
    exec_word(enc_roff(1'b1, 1'b1, 5'd31, 5'd0, 5'd5), 21'($urandom));
    exec_word(enc_roff(1'b0, 1'b0, 5'd5, 5'd4, 5'd0), 21'($urandom));
    exec_word(enc_lit(1'b1, 19'h3FFFF, 5'd6), 21'h1FFFFC);
    exec_word(enc_lit(1'b0, 19'h40000, 5'd31), 21'd0);
    wait_drained();
  endtask

  task automatic run_sequence();
    logic [20:0] win;
    logic [4:0]  base_reg [3];
    logic [31:0] ins;
    logic [20:0] pc;
    logic        sz8;
    logic        ld;
    logic [4:0]  xn;
    logic [4:0]  xm;
    logic [4:0]  rt;
    logic [11:0] imm;
    int          steps;
    case ($urandom_range(0, 3))
      0: win = 21'h1FFF00;
      1: win = 21'($urandom);
      default: win = 21'($urandom_range(0, 1023));
    endcase
    for (int k = 0; k < 3; k++) begin
      base_reg[k] = 5'($urandom);
      send_word(lsua64_pkg::MODE_SET_REG, $urandom, 21'($urandom),
                {13'($urandom), base_reg[k]},
                {32'($urandom), 11'($urandom), win + 21'($urandom_range(0, 255))});
    end
    steps = $urandom_range(4, 12);
    repeat (steps) begin
      sz8 = 1'($urandom);
      ld = 1'($urandom);
      xn = base_reg[$urandom_range(0, 2)];
      xm = base_reg[$urandom_range(0, 2)];
      rt = ($urandom_range(0, 2) == 0) ? base_reg[$urandom_range(0, 2)] : 5'($urandom);
      imm = ($urandom_range(0, 3) == 0) ? 12'($urandom) : 12'($urandom_range(0, 15));
      pc = win + 21'($urandom_range(0, 255));
      case ($urandom_range(0, 7))
        0: ins = enc_lit(sz8, 19'($urandom_range(0, 127) - 64), rt);
        1, 2: ins = enc_uoff(sz8, ld, imm, xn, rt);
        3, 4: ins = enc_roff(sz8, ld, xm, xn, rt);
        default: ins = enc_idx(sz8, ld, 9'($urandom), 1'($urandom), xn, rt);
      endcase
      exec_word(ins, pc);
    end
  endtask

  task automatic test_random_sequences();
    while (words_sent < RANDOM_WORDS) begin
      src_gaps = $urandom_range(0, 3) != 0;
      sink_stalls = $urandom_range(0, 3) != 0;
      run_sequence();
      if ($urandom_range(0, 15) == 0) begin
        wait_drained();
      end
    end
  endtask

  task automatic test_noise();
    logic [1:0] mode;
    src_gaps = 1'b1;
    sink_stalls = 1'b1;
    while (words_sent < TOTAL_WORDS) begin
      mode = 2'($urandom);
      if (mode == lsua64_pkg::MODE_EXEC) begin
        exec_word($urandom, 21'($urandom));
      end else begin
        send_word(mode, $urandom, 21'($urandom), 18'($urandom), {$urandom, $urandom});
      end
    end
  endtask

  initial begin : result_sink
    int      stall;
    access_t want;
    wait (rst_n === 1'b1);
    forever begin
      stall = sink_stalls ? $urandom_range(0, 4) : 0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      if (access_q.size() == 0) begin
        $error("result word with no pending access");
        mismatches++;
      end else begin
        want = access_q.pop_front();
        if (out_eff_address !== want.eff_address) begin
          $error("eff_address: expected %0h, got %0h", want.eff_address, out_eff_address);
          mismatches++;
        end
        if (out_is_load !== want.is_load) begin
          $error("is_load: expected %0h, got %0h", want.is_load, out_is_load);
          mismatches++;
        end
        if (out_target_reg !== want.target_reg) begin
          $error("target_reg: expected %0d, got %0d", want.target_reg, out_target_reg);
          mismatches++;
        end
        if (out_moved_data !== want.moved_data) begin
          $error("moved_data: expected %0h, got %0h", want.moved_data, out_moved_data);
          mismatches++;
        end
        if (out_base_written !== want.base_written) begin
          $error("base_written: expected %0h, got %0h", want.base_written, out_base_written);
          mismatches++;
        end
      end
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
        idle = 0;
      end else begin
        idle++;
      end
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_presets();
    test_addressing();
    test_random_sequences();
    test_noise();
    wait_drained();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
